// ----- rtl/glossy_specular_brdf_unit_macros.svh -----
// Assertion helpers shared by the RTL.
`ifndef GLOSSY_SPECULAR_BRDF_UNIT_MACROS_SVH
`define GLOSSY_SPECULAR_BRDF_UNIT_MACROS_SVH

// Clocked assertion, disabled during reset.
`define GSB_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion, active during reset as well.
`define GSB_ASSERT_NR(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/gsb_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package gsb_pkg;

   localparam int VEC_WIDTH  = 16;
   localparam int REQ_DATA_W = ((9 * VEC_WIDTH + 7) / 8) * 8;
   localparam int RSP_DATA_W = 16;
   localparam int CFG_W      = 16;
   localparam int CSR_IDX_W  = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_SPEC_COEFF    = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SPEC_EXPONENT = 1'd1;

   localparam int Q_W     = 16;
   localparam int NW_W    = 32;
   localparam int D_W     = 34;
   localparam int BIG_W   = 51;
   localparam int R_W     = 28;
   localparam int RR_W    = 56;
   localparam int RV_W    = 44;
   localparam int S_W     = 56;
   localparam int P_W     = 45;
   localparam int ROOT_W  = 28;
   localparam int C_W     = 20;
   localparam int LOG_M_W = 31;
   localparam int FRAC_W  = 16;
   localparam int IPL_W   = 6;
   localparam int Y_W     = 31;
   localparam int IP_W    = 6;
   localparam int RAW_W   = 47;
   localparam int SH_W    = 6;

   typedef logic signed [Q_W-1:0] q14_type;

   function automatic q14_type to_q14(input logic [VEC_WIDTH-1:0] raw);
      logic [VEC_WIDTH+15:0] ext;
      ext = {raw, 16'd0};
      return q14_type'(ext[VEC_WIDTH+15 -: 16]);
   endfunction

   function automatic logic [63:0] isqrt_const(input logic [63:0] v);
      logic [63:0] res;
      logic [63:0] t;
      res = '0;
      for (int b = 31; b >= 0; b--) begin
         t = res | (64'd1 << b);
         if (t * t <= v) res = t;
      end
      return res;
   endfunction

   // 2^(2^-j) in Q1.30
   function automatic logic [LOG_M_W-1:0] exp_root(input int j);
      logic [63:0] s;
      s = 64'd1 << 31;
      for (int k = 1; k <= j; k++) s = isqrt_const(s << 30);
      return s[LOG_M_W-1:0];
   endfunction

endpackage

`default_nettype wire

// ----- rtl/glossy_specular_brdf_unit.sv -----
// Throughput: one sample per cycle while the output is not stalled; the whole pipeline advances on one enable.
// Depth is set by the 28-stage square root, 20-stage divider and the
// 16-stage log2 and exp2 multiplier chains.
// Reset (synchronous, active high) clears all valid bits and both registers.
`timescale 1ns / 1ps
`default_nettype none
`include "glossy_specular_brdf_unit_macros.svh"

module glossy_specular_brdf_unit
   import gsb_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // normal_x, normal_y, normal_z, light_x, light_y, light_z, view_x, view_y, view_z
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // intensity
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CFG_W-1:0]      csr_wdata
);

   logic ce;
   logic [CFG_W-1:0] spec_coeff_ff, spec_exponent_ff;

   assign ce         = !rsp_tvalid || rsp_tready;
   assign req_tready = ce;

   always_ff @(posedge clock) begin
      if (reset) begin
         spec_coeff_ff    <= '0;
         spec_exponent_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_SPEC_COEFF:    spec_coeff_ff    <= csr_wdata;
            CSR_SPEC_EXPONENT: spec_exponent_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---------------- front: dot products and reflection ----------------
   logic [5:0] f_vld_ff;
   q14_type f1_n_ff [3], f1_w_ff [3], f1_v_ff [3];
   q14_type f2_n_ff [3], f2_w_ff [3], f2_v_ff [3];
   q14_type f3_n_ff [3], f3_w_ff [3], f3_v_ff [3];
   q14_type f4_v_ff [3], f5_v_ff [3];
   logic signed [NW_W-1:0]  f2_nw_ff [3];
   logic signed [D_W-1:0]   f3_d_ff;
   logic signed [BIG_W-1:0] f4_big_ff [3];
   logic signed [R_W-1:0]   f5_r_ff [3];
   logic [RR_W-1:0]         f6_rr_ff [3];
   logic signed [RV_W-1:0]  f6_rv_ff [3];

   logic signed [BIG_W-1:0] big_in [3];
   logic signed [R_W-1:0]   r_in [3];
   logic [S_W-1:0]          s_in;
   logic signed [P_W-1:0]   p_in;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         big_in[i] = ((BIG_W'(f3_d_ff) * BIG_W'(f3_n_ff[i])) <<< 1)
                   - (BIG_W'(f3_w_ff[i]) <<< 28);
         r_in[i]   = R_W'((f4_big_ff[i] + (BIG_W'(1) <<< 21)) >>> 22);
      end
      s_in = S_W'(f6_rr_ff[0]) + S_W'(f6_rr_ff[1]) + S_W'(f6_rr_ff[2]);
      p_in = P_W'(f6_rv_ff[0]) + P_W'(f6_rv_ff[1]) + P_W'(f6_rv_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (reset) f_vld_ff <= '0;
      else if (ce) f_vld_ff <= {f_vld_ff[4:0], req_tvalid};
   end

   // sqrt stage 0 is loaded by the front
   logic [ROOT_W:0]         sq_vld_ff;
   logic [S_W-1:0]          sq_rem_ff  [0:ROOT_W];
   logic [ROOT_W-1:0]       sq_root_ff [0:ROOT_W];
   logic signed [P_W-1:0]   sq_p_ff    [0:ROOT_W];
   logic                    sq_kill_ff [0:ROOT_W];

   always_ff @(posedge clock) begin
      if (ce) begin
         for (int i = 0; i < 3; i++) begin
            f1_n_ff[i]   <= to_q14(req_tdata[i*VEC_WIDTH +: VEC_WIDTH]);
            f1_w_ff[i]   <= to_q14(req_tdata[(3+i)*VEC_WIDTH +: VEC_WIDTH]);
            f1_v_ff[i]   <= to_q14(req_tdata[(6+i)*VEC_WIDTH +: VEC_WIDTH]);
            f2_nw_ff[i]  <= f1_n_ff[i] * f1_w_ff[i];
            f2_n_ff[i]   <= f1_n_ff[i];
            f2_w_ff[i]   <= f1_w_ff[i];
            f2_v_ff[i]   <= f1_v_ff[i];
            f3_n_ff[i]   <= f2_n_ff[i];
            f3_w_ff[i]   <= f2_w_ff[i];
            f3_v_ff[i]   <= f2_v_ff[i];
            f4_big_ff[i] <= big_in[i];
            f4_v_ff[i]   <= f3_v_ff[i];
            f5_r_ff[i]   <= r_in[i];
            f5_v_ff[i]   <= f4_v_ff[i];
            f6_rr_ff[i]  <= RR_W'(RR_W'(f5_r_ff[i]) * RR_W'(f5_r_ff[i]));
            f6_rv_ff[i]  <= f5_r_ff[i] * f5_v_ff[i];
         end
         f3_d_ff       <= D_W'(f2_nw_ff[0]) + D_W'(f2_nw_ff[1]) + D_W'(f2_nw_ff[2]);
         sq_rem_ff[0]  <= s_in;
         sq_root_ff[0] <= '0;
         sq_p_ff[0]    <= p_in;
         sq_kill_ff[0] <= (s_in == '0) || p_in[P_W-1] || (p_in == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) sq_vld_ff <= '0;
      else if (ce) sq_vld_ff <= {sq_vld_ff[ROOT_W-1:0], f_vld_ff[5]};
   end

   // ---------------- square root, one root bit per stage ----------------
   for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
      localparam int B = ROOT_W - 1 - k;
      logic [S_W:0]      trial_in;
      logic              take_in;
      assign trial_in = ((S_W+1)'(sq_root_ff[k]) << (B + 1)) + ((S_W+1)'(1) << (2 * B));
      assign take_in  = trial_in <= {1'b0, sq_rem_ff[k]};
      always_ff @(posedge clock) begin
         if (ce) begin
            sq_rem_ff[k+1]  <= take_in ? sq_rem_ff[k] - trial_in[S_W-1:0] : sq_rem_ff[k];
            sq_root_ff[k+1] <= take_in ? sq_root_ff[k] | (ROOT_W'(1) << B) : sq_root_ff[k];
            sq_p_ff[k+1]    <= sq_p_ff[k];
            sq_kill_ff[k+1] <= sq_kill_ff[k];
         end
      end
   end

   // ---------------- divider c = 4p / len, one quotient bit per stage ----------------
   logic [C_W-1:0]          dv_vld_ff;
   logic [ROOT_W-1:0]       dv_rem_ff  [C_W];
   logic [C_W-1:0]          dv_q_ff    [C_W];
   logic [ROOT_W-1:0]       dv_len_ff  [C_W];
   logic signed [P_W-1:0]   dv_p_ff    [C_W];
   logic                    dv_kill_ff [C_W];

   always_ff @(posedge clock) begin
      if (reset) dv_vld_ff <= '0;
      else if (ce) dv_vld_ff <= {dv_vld_ff[C_W-2:0], sq_vld_ff[ROOT_W]};
   end

   for (genvar k = 0; k < C_W; k++) begin : g_div
      localparam int I = C_W - 1 - k;
      logic [ROOT_W-1:0]     rem_p, len_p;
      logic [C_W-1:0]        q_p;
      logic signed [P_W-1:0] p_p;
      logic                  kill_p, dbit;
      logic [ROOT_W:0]       sh_in;
      logic                  ge_in;
      if (k == 0) begin : g_first
         assign rem_p  = ROOT_W'(sq_p_ff[ROOT_W][P_W-2:C_W-2]);
         assign len_p  = sq_root_ff[ROOT_W];
         assign q_p    = '0;
         assign p_p    = sq_p_ff[ROOT_W];
         assign kill_p = sq_kill_ff[ROOT_W];
      end else begin : g_next
         assign rem_p  = dv_rem_ff[k-1];
         assign len_p  = dv_len_ff[k-1];
         assign q_p    = dv_q_ff[k-1];
         assign p_p    = dv_p_ff[k-1];
         assign kill_p = dv_kill_ff[k-1];
      end
      if (I >= 2) begin : g_bit
         assign dbit = p_p[I-2];
      end else begin : g_zero
         assign dbit = 1'b0;
      end
      assign sh_in = {rem_p, dbit};
      assign ge_in = sh_in >= {1'b0, len_p};
      always_ff @(posedge clock) begin
         if (ce) begin
            dv_rem_ff[k]  <= ge_in ? ROOT_W'(sh_in - {1'b0, len_p}) : sh_in[ROOT_W-1:0];
            dv_q_ff[k]    <= {q_p[C_W-2:0], ge_in};
            dv_len_ff[k]  <= len_p;
            dv_p_ff[k]    <= p_p;
            dv_kill_ff[k] <= kill_p;
         end
      end
   end

   // ---------------- log2: normalize, then squaring stages ----------------
   logic [FRAC_W:0]           lg_vld_ff;
   logic [LOG_M_W-1:0]        lg_m_ff    [0:FRAC_W];
   logic [FRAC_W-1:0]         lg_frac_ff [0:FRAC_W];
   logic signed [IPL_W-1:0]   lg_ipl_ff  [0:FRAC_W];
   logic                      lg_kill_ff [0:FRAC_W];
   logic                      lg_zc_ff   [0:FRAC_W];

   logic [C_W-1:0] c_in;
   logic [4:0]     pos_in;

   always_comb begin
      c_in   = dv_q_ff[C_W-1];
      pos_in = '0;
      for (int b = 0; b < C_W; b++) begin
         if (c_in[b]) pos_in = 5'(b);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) lg_vld_ff <= '0;
      else if (ce) lg_vld_ff <= {lg_vld_ff[FRAC_W-1:0], dv_vld_ff[C_W-1]};
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         lg_m_ff[0]    <= LOG_M_W'(c_in) << (5'd30 - pos_in);
         lg_frac_ff[0] <= '0;
         lg_ipl_ff[0]  <= $signed(IPL_W'(pos_in)) - IPL_W'(16);
         lg_kill_ff[0] <= dv_kill_ff[C_W-1];
         lg_zc_ff[0]   <= c_in == '0;
      end
   end

   for (genvar k = 0; k < FRAC_W; k++) begin : g_log
      logic [2*LOG_M_W-1:0] prod_in;
      logic [LOG_M_W:0]     t_in;
      assign prod_in = lg_m_ff[k] * lg_m_ff[k];
      assign t_in    = prod_in[2*LOG_M_W-1:30];
      always_ff @(posedge clock) begin
         if (ce) begin
            lg_m_ff[k+1]    <= t_in[LOG_M_W] ? t_in[LOG_M_W:1] : t_in[LOG_M_W-1:0];
            lg_frac_ff[k+1] <= {lg_frac_ff[k][FRAC_W-2:0], t_in[LOG_M_W]};
            lg_ipl_ff[k+1]  <= lg_ipl_ff[k];
            lg_kill_ff[k+1] <= lg_kill_ff[k];
            lg_zc_ff[k+1]   <= lg_zc_ff[k];
         end
      end
   end

   // ---------------- y = log2(c) * e, special cases ----------------
   logic signed [IPL_W+FRAC_W-1:0]       l2_in;
   logic signed [IPL_W+FRAC_W+CFG_W:0]   le_in;
   logic signed [Y_W-1:0]                y_in;
   logic signed [Y_W-17:0]               ip_in;
   logic                                 force_in;
   logic [RSP_DATA_W-1:0]                fval_in;

   always_comb begin
      l2_in    = {lg_ipl_ff[FRAC_W], lg_frac_ff[FRAC_W]};
      le_in    = l2_in * $signed({1'b0, spec_exponent_ff});
      y_in     = Y_W'(le_in >>> 8);
      ip_in    = y_in[Y_W-1:16];
      force_in = 1'b1;
      fval_in  = '0;
      if (lg_kill_ff[FRAC_W]) begin
         fval_in = '0;
      end else if (lg_zc_ff[FRAC_W]) begin
         fval_in = (spec_exponent_ff == '0) ? spec_coeff_ff : '0;
      end else if ((spec_coeff_ff == '0) || (ip_in <= -18)) begin
         fval_in = '0;
      end else if (ip_in >= 17) begin
         fval_in = '1;
      end else begin
         force_in = 1'b0;
      end
   end

   logic [FRAC_W:0]          ex_vld_ff;
   logic [LOG_M_W-1:0]       ex_val_ff   [0:FRAC_W];
   logic [FRAC_W-1:0]        ex_f_ff     [0:FRAC_W];
   logic signed [IP_W-1:0]   ex_ip_ff    [0:FRAC_W];
   logic                     ex_force_ff [0:FRAC_W];
   logic [RSP_DATA_W-1:0]    ex_fval_ff  [0:FRAC_W];

   always_ff @(posedge clock) begin
      if (reset) ex_vld_ff <= '0;
      else if (ce) ex_vld_ff <= {ex_vld_ff[FRAC_W-1:0], lg_vld_ff[FRAC_W]};
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         ex_val_ff[0]   <= LOG_M_W'(1) << 30;
         ex_f_ff[0]     <= y_in[FRAC_W-1:0];
         ex_ip_ff[0]    <= IP_W'(ip_in);
         ex_force_ff[0] <= force_in;
         ex_fval_ff[0]  <= fval_in;
      end
   end

   // ---------------- exp2 of the fraction, one root per stage ----------------
   for (genvar k = 0; k < FRAC_W; k++) begin : g_exp
      localparam logic [LOG_M_W-1:0] ROOT = exp_root(k + 1);
      logic [2*LOG_M_W-1:0] prod_in;
      assign prod_in = ex_val_ff[k] * ROOT;
      always_ff @(posedge clock) begin
         if (ce) begin
            ex_val_ff[k+1]   <= ex_f_ff[k][FRAC_W-1-k] ? prod_in[LOG_M_W+29:30] : ex_val_ff[k];
            ex_f_ff[k+1]     <= ex_f_ff[k];
            ex_ip_ff[k+1]    <= ex_ip_ff[k];
            ex_force_ff[k+1] <= ex_force_ff[k];
            ex_fval_ff[k+1]  <= ex_fval_ff[k];
         end
      end
   end

   // ---------------- scale by ks, shift and saturate ----------------
   logic                  ml_vld_ff;
   logic [RAW_W-1:0]      ml_raw_ff;
   logic [SH_W-1:0]       ml_sh_ff;
   logic                  ml_force_ff;
   logic [RSP_DATA_W-1:0] ml_fval_ff;
   logic                  rsp_vld_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic [RAW_W-1:0]      res_in;
   logic [RSP_DATA_W-1:0] out_in;

   always_comb begin
      res_in = ml_raw_ff >> ml_sh_ff;
      if (ml_force_ff) out_in = ml_fval_ff;
      else if (|res_in[RAW_W-1:RSP_DATA_W]) out_in = '1;
      else out_in = res_in[RSP_DATA_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ml_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else if (ce) begin
         ml_vld_ff  <= ex_vld_ff[FRAC_W];
         rsp_vld_ff <= ml_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ce) begin
         ml_raw_ff   <= RAW_W'(spec_coeff_ff) * RAW_W'(ex_val_ff[FRAC_W]);
         ml_sh_ff    <= SH_W'(IP_W'(30) - ex_ip_ff[FRAC_W]);
         ml_force_ff <= ex_force_ff[FRAC_W];
         ml_fval_ff  <= ex_fval_ff[FRAC_W];
         rsp_data_ff <= out_in;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;

   `GSB_ASSERT(a_front_advance, clock, reset, (f_vld_ff[0] && ce) |=> f_vld_ff[1], "front stage lost a sample")
   `GSB_ASSERT_NR(a_reset_empty, clock, reset |=> !rsp_tvalid, "result valid right after reset")
   `GSB_ASSERT(a_csr_coeff, clock, reset, (csr_we && csr_index == CSR_SPEC_COEFF) |=> (spec_coeff_ff == $past(csr_wdata)), "spec_coeff write not taken")

endmodule

`default_nettype wire

// ----- sim/glossy_specular_brdf_checker.sv -----
`timescale 1ns / 1ps

module glossy_specular_brdf_checker
   import gsb_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CFG_W-1:0]      csr_wdata,
   output int                    fail_count,
   output int                    pending_count
);

   logic [15:0] ks_reg;
   logic [15:0] exp_reg;
   logic [15:0] intensity_q[$];

   assign pending_count = intensity_q.size();

   function automatic longint sq14(input logic [VEC_WIDTH-1:0] raw);
      logic signed [15:0] v;
      v = raw;
      return longint'(v);
   endfunction

   function automatic longint fshr(input longint x, input int s);
      return x >>> s;
   endfunction

   function automatic longint unsigned int_sqrt(input longint unsigned v);
      longint unsigned res, t;
      res = 0;
      for (int b = 31; b >= 0; b--) begin
         t = res | (64'd1 << b);
         if (t * t <= v) res = t;
      end
      return res;
   endfunction

   function automatic longint log2_fix(input longint unsigned c);
      int p;
      longint unsigned m;
      longint fr;
      p = 0;
      fr = 0;
      while (p < 62 && (c >> (p + 1)) != 0) p++;
      m = (p <= 30) ? (c << (30 - p)) : (c >> (p - 30));
      for (int k = 0; k < 16; k++) begin
         m = (m * m) >> 30;
         fr = fr << 1;
         if (m >= (64'd2 << 30)) begin
            fr = fr | 1;
            m = m >> 1;
         end
      end
      return longint'(p - 16) * 65536 + fr;
   endfunction

   function automatic longint unsigned exp2_fix(input longint unsigned f);
      longint unsigned val, s;
      val = 64'd1 << 30;
      s = 64'd2 << 30;
      for (int j = 1; j <= 16; j++) begin
         s = int_sqrt(s << 30);
         if ((f >> (16 - j)) & 1) val = (val * s) >> 30;
      end
      return val;
   endfunction

   function automatic logic [15:0] predict_intensity(input logic [REQ_DATA_W-1:0] td);
      longint n[3], w[3], v[3], r[3];
      longint d, p, l2, y, ip, big;
      longint unsigned s, len, c, val, res;
      d = 0;
      p = 0;
      s = 0;
      for (int i = 0; i < 3; i++) begin
         n[i] = sq14(td[i*VEC_WIDTH +: VEC_WIDTH]);
         w[i] = sq14(td[(3+i)*VEC_WIDTH +: VEC_WIDTH]);
         v[i] = sq14(td[(6+i)*VEC_WIDTH +: VEC_WIDTH]);
         d += n[i] * w[i];
      end
      for (int i = 0; i < 3; i++) begin
         big = 2 * d * n[i] - w[i] * (64'sd1 <<< 28);
         r[i] = fshr(big + (64'sd1 <<< 21), 22);
         s += longint'(r[i] * r[i]);
         p += r[i] * v[i];
      end
      if (s == 0 || p <= 0) return 16'd0;
      len = int_sqrt(s);
      c = (longint'(p) * 4) / len;
      if (c == 0) return (exp_reg == 0) ? ks_reg : 16'd0;
      l2 = log2_fix(c);
      y = fshr(l2 * longint'(exp_reg), 8);
      ip = fshr(y, 16);
      if (ks_reg == 0 || ip <= -18) return 16'd0;
      if (ip >= 17) return 16'hFFFF;
      val = exp2_fix(y - ip * 65536);
      res = (longint'(ks_reg) * val) >> (30 - ip);
      return (res > 16'hFFFF) ? 16'hFFFF : res[15:0];
   endfunction

   task automatic report_mismatch(input string msg);
      $display("mismatch @%0t: %s", $time, msg);
      fail_count++;
   endtask

   initial fail_count = 0;

   always @(posedge clock) begin
      if (reset) begin
         ks_reg <= '0;
         exp_reg <= '0;
         intensity_q.delete();
      end else begin
         if (req_tvalid && req_tready) intensity_q.push_back(predict_intensity(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            if (intensity_q.size() == 0) begin
               report_mismatch($sformatf("unexpected transfer %h", rsp_tdata));
            end else if (rsp_tdata !== intensity_q[0]) begin
               report_mismatch($sformatf("intensity got %h exp %h", rsp_tdata, intensity_q[0]));
               void'(intensity_q.pop_front());
            end else begin
               void'(intensity_q.pop_front());
            end
         end
         if (csr_we) begin
            if (csr_index == CSR_SPEC_COEFF) ks_reg <= csr_wdata;
            else if (csr_index == CSR_SPEC_EXPONENT) exp_reg <= csr_wdata;
         end
      end
   end

endmodule

// ----- sim/glossy_specular_brdf_unit_tb.sv -----
`timescale 1ns / 1ps

module glossy_specular_brdf_unit_tb;
   import gsb_pkg::*;

   localparam int LATENCY = 91;
   localparam int MAX_CYCLES = 400000;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CFG_W-1:0]      csr_wdata;
   int                    fail_count;
   int                    pending_count;
   int                    cycle_count;
   int                    stall_mode;

   glossy_specular_brdf_unit DUT (.*);

   glossy_specular_brdf_checker checker_i (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > MAX_CYCLES) begin
            $display("glossy_specular_brdf_unit regression: fail");
            $finish;
         end
      end
   end

   // receiver stall pattern, changes mode every so often
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         case (stall_mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= ($urandom_range(0, 3) != 0);
            2: rsp_tready <= ($urandom_range(0, 3) == 0);
            default: rsp_tready <= cycle_count[2];
         endcase
      end
   end

   function automatic logic [15:0] unit_comp();
      case ($urandom_range(0, 5))
         0: return 16'sd16384;
         1: return -16'sd16384;
         2: return 16'sd11585;
         3: return -16'sd11585;
         4: return 16'sd0;
         default: return 16'($urandom_range(0, 32768) - 16384);
      endcase
   endfunction

   task automatic send_sample(input logic [REQ_DATA_W-1:0] td);
      req_tvalid <= 1'b1;
      req_tdata <= td;
      do @(posedge clock); while (!req_tready);
      req_tvalid <= 1'b0;
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic drain();
      while (pending_count != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
   endtask

   function automatic logic [REQ_DATA_W-1:0] pack(input logic [15:0] c[9]);
      logic [REQ_DATA_W-1:0] td;
      td = '0;
      for (int i = 0; i < 9; i++) td[i*VEC_WIDTH +: VEC_WIDTH] = c[i];
      return td;
   endfunction

   task automatic random_phase(input int count);
      logic [15:0] c[9];
      int burst;
      int sent;
      sent = 0;
      while (sent < count) begin
         burst = $urandom_range(1, 40);
         for (int b = 0; b < burst && sent < count; b++) begin
            if ($urandom_range(0, 9) < 7) begin
               for (int i = 0; i < 9; i++) c[i] = unit_comp();
               // copy the light direction into the view now and then
               if ($urandom_range(0, 2) == 0) begin
                  c[6] = c[3];
                  c[7] = c[4];
                  c[8] = c[5];
               end
            end else begin
               for (int i = 0; i < 9; i++) c[i] = 16'($urandom);
            end
            req_tvalid <= 1'b1;
            req_tdata <= pack(c);
            do @(posedge clock); while (!req_tready);
            sent++;
         end
         req_tvalid <= 1'b0;
         if ($urandom_range(0, 2) != 0) repeat ($urandom_range(1, 12)) @(posedge clock);
         if ($urandom_range(0, 30) == 0) stall_mode = $urandom_range(0, 3);
      end
      req_tvalid <= 1'b0;
   endtask

   initial begin
      logic [15:0] c[9];
      logic [15:0] ks_set[6];
      logic [15:0] ex_set[6];
      req_tvalid = 0;
      req_tdata = '0;
      csr_we = 0;
      csr_index = '0;
      csr_wdata = '0;
      stall_mode = 0;
      reset = 1;
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: reset registers, then typical setting
      c = '{16384, 0, 0, 0, 11585, 11585, 0, -16'sd11585, 11585};
      send_sample(pack(c));
      drain();
      write_csr(CSR_SPEC_COEFF, 16'h1000);
      write_csr(CSR_SPEC_EXPONENT, 16'h0A00);
      // mirror direction
      c = '{0, 0, 16384, 0, 11585, 11585, 0, -16'sd11585, 11585};
      send_sample(pack(c));
      // view equals light: cosine negative or small
      c = '{0, 0, 16384, 0, 11585, 11585, 0, 11585, 11585};
      send_sample(pack(c));
      // zero reflection
      c = '{0, 0, 0, 0, 0, 0, 0, 0, 16384};
      send_sample(pack(c));
      // negative cosine
      c = '{0, 0, 16384, 0, 0, 16384, 0, 0, -16'sd16384};
      send_sample(pack(c));
      // tiny cosine
      c = '{0, 0, 16384, 0, 0, 16384, 16384, 0, 1};
      send_sample(pack(c));
      // extremes of every field
      for (int i = 0; i < 9; i++) c[i] = 16'h7FFF;
      send_sample(pack(c));
      for (int i = 0; i < 9; i++) c[i] = 16'h8000;
      send_sample(pack(c));
      c = '{16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000};
      send_sample(pack(c));
      drain();
      // exponent zero: tiny cosine gives ks
      write_csr(CSR_SPEC_EXPONENT, 16'h0000);
      write_csr(CSR_SPEC_COEFF, 16'hFFFF);
      c = '{0, 0, 16384, 0, 0, 16384, 16384, 0, 1};
      send_sample(pack(c));
      c = '{0, 0, 16384, 0, 11585, 11585, 0, -16'sd11585, 11585};
      send_sample(pack(c));
      drain();
      // huge exponent with super-unit cosine saturates; with sub-unit goes to zero
      write_csr(CSR_SPEC_EXPONENT, 16'hFFFF);
      for (int i = 0; i < 9; i++) c[i] = 16'h7FFF;
      send_sample(pack(c));
      c = '{0, 0, 16384, 0, 11585, 11585, 0, -16'sd8000, 11585};
      send_sample(pack(c));
      drain();

      ks_set = '{16'h0000, 16'hFFFF, 16'h1000, 16'h0800, 16'h2000, 16'h0001};
      ex_set = '{16'h0000, 16'hFFFF, 16'h0100, 16'h2000, 16'h0080, 16'h0A40};
      for (int ph = 0; ph < 8; ph++) begin
         if (ph < 6) begin
            write_csr(CSR_SPEC_COEFF, ks_set[ph]);
            write_csr(CSR_SPEC_EXPONENT, ex_set[ph]);
         end else begin
            write_csr(CSR_SPEC_COEFF, 16'($urandom));
            write_csr(CSR_SPEC_EXPONENT, 16'($urandom_range(0, 16'h3000)));
         end
         stall_mode = ph % 4;
         random_phase(105);
         drain();
      end

      if (fail_count == 0) begin
         $display("glossy_specular_brdf_unit regression: pass");
      end else begin
         $display("glossy_specular_brdf_unit regression: fail");
      end
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/gsb_pkg.sv
rtl/glossy_specular_brdf_unit.sv
sim/glossy_specular_brdf_checker.sv
sim/glossy_specular_brdf_unit_tb.sv
